### rtl/bres_pkg.sv
// ----------------------------------------------------------------------------
// bres_pkg
// Shared types, constants and helpers for the line rasterizer.
// ----------------------------------------------------------------------------
package bres_pkg;

  localparam int GRID_SIZE = 64;
  localparam int COORD_W   = 6;
  localparam int STRIDE_W  = 7;
  localparam int ADDR_W    = 12;
  localparam int ERR_W     = COORD_W + 2;
  localparam int PROD_W    = COORD_W + STRIDE_W;

  localparam logic [COORD_W-1:0]  COORD_MAX    = COORD_W'(GRID_SIZE - 1);
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(64);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } bres_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture a new segment and set up the walk
    logic step;   // emit the current pixel and advance
  } bres_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic at_end;    // current major coordinate is the final one
    logic out_free;  // output register can take a pixel this cycle
  } bres_status_t;

  function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
    return (v > COORD_MAX) ? COORD_MAX : v;
  endfunction

endpackage

### rtl/bres_ctrl.sv
// ----------------------------------------------------------------------------
// bres_ctrl
// Controller: sequences set-up and the per-pixel walk of one segment.
// ----------------------------------------------------------------------------
module bres_ctrl
  import bres_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  bres_status_t status,
  output bres_cmd_t    cmd
);

  bres_state_t state;
  bres_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (status.out_free && status.at_end) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    cmd      = '0;
    case (state)
      ST_IDLE: begin
        // hold off requests while reset is applied
        in_stall = rst;
        cmd.load = in_valid && !rst;
      end
      ST_RUN: begin
        cmd.step = status.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

### rtl/bres_dp.sv
// ----------------------------------------------------------------------------
// bres_dp
// Datapath: segment set-up, error accumulator, minor stepping, address
// multiply and the output register.
// ----------------------------------------------------------------------------
module bres_dp
  import bres_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [STRIDE_W-1:0] cfg_wdata,
  input  logic [COORD_W-1:0]  start_x,
  input  logic [COORD_W-1:0]  start_y,
  input  logic [COORD_W-1:0]  end_x,
  input  logic [COORD_W-1:0]  end_y,
  input  bres_cmd_t           cmd,
  output bres_status_t        status,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [COORD_W-1:0]  pixel_x,
  output logic [COORD_W-1:0]  pixel_y,
  output logic [ADDR_W-1:0]   pixel_address,
  output logic                last_pixel
);

  // configuration
  logic [STRIDE_W-1:0] line_stride;

  // walk state
  logic               x_major;
  logic               step_up;
  logic [COORD_W-1:0] maj;
  logic [COORD_W-1:0] maj_end;
  logic [COORD_W-1:0] minor;
  logic [COORD_W-1:0] dmaj;
  logic [COORD_W-1:0] dmin;
  logic [ERR_W-1:0]   err;

  // set-up from the input ports
  logic [COORD_W-1:0] x0, y0, x1, y1;
  logic [COORD_W-1:0] adx, ady;
  logic               xm;
  logic [COORD_W-1:0] ma0, mi0, ma1, mi1;
  logic [COORD_W-1:0] sma0, smi0, sma1, smi1;

  // step logic
  logic [ERR_W-1:0]   err_add;
  logic [ERR_W-1:0]   dmaj2;
  logic               minor_move;
  logic [COORD_W-1:0] cur_x, cur_y;
  logic [PROD_W-1:0]  prod;
  logic [ADDR_W-1:0]  addr_next;

  always_comb begin
    x0  = clamp_coord(start_x);
    y0  = clamp_coord(start_y);
    x1  = clamp_coord(end_x);
    y1  = clamp_coord(end_y);
    adx = (x1 > x0) ? (x1 - x0) : (x0 - x1);
    ady = (y1 > y0) ? (y1 - y0) : (y0 - y1);
    xm  = (adx >= ady);
    ma0 = xm ? x0 : y0;
    mi0 = xm ? y0 : x0;
    ma1 = xm ? x1 : y1;
    mi1 = xm ? y1 : x1;
    // swap so the major coordinate rises
    if (ma1 < ma0) begin
      sma0 = ma1;
      smi0 = mi1;
      sma1 = ma0;
      smi1 = mi0;
    end else begin
      sma0 = ma0;
      smi0 = mi0;
      sma1 = ma1;
      smi1 = mi1;
    end
  end

  always_comb begin
    dmaj2      = {1'b0, dmaj, 1'b0};
    err_add    = err + {1'b0, dmin, 1'b0};
    minor_move = (err_add > dmaj2);
    cur_x      = x_major ? maj : minor;
    cur_y      = x_major ? minor : maj;
    prod       = PROD_W'(cur_y) * PROD_W'(line_stride);
    addr_next  = ADDR_W'(prod) + ADDR_W'(cur_x);
  end

  assign status.at_end   = (maj == maj_end);
  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_stride <= STRIDE_RESET;
    end else if (cfg_we) begin
      line_stride <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_major <= xm;
      maj     <= sma0;
      maj_end <= sma1;
      minor   <= smi0;
      step_up <= (smi1 > smi0);
      dmaj    <= sma1 - sma0;
      dmin    <= (smi1 > smi0) ? (smi1 - smi0) : (smi0 - smi1);
      err     <= ERR_W'(sma1 - sma0);
    end else if (cmd.step) begin
      maj <= maj + COORD_W'(1);
      if (minor_move) begin
        minor <= step_up ? (minor + COORD_W'(1)) : (minor - COORD_W'(1));
        err   <= err_add - dmaj2;
      end else begin
        err <= err_add;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      pixel_x       <= cur_x;
      pixel_y       <= cur_y;
      pixel_address <= addr_next;
      last_pixel    <= status.at_end;
    end
  end

endmodule

### rtl/bresenham_line_rasterizer.sv
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer
// Walks one line segment per request and emits every covered pixel with
// its framebuffer address.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake            Payload
//  -------  -------------------  ------------------------------------------
//  in       in_valid / in_stall  start_x, start_y, end_x, end_y
//  out      out_valid/out_stall  pixel_x, pixel_y, pixel_address, last_pixel
//  cfg      cfg_we               cfg_wdata (line_stride, reset 64)
//
//  A segment of N pixels (N = major delta + 1, 1..64) is taken in by an
//  accept step that does the delta and swap set-up; the error-accumulator
//  loop in bres_dp then emits one pixel per cycle while out_stall allows.
//  Output stalls freeze the walk; the output register keeps a finished pixel
//  while the next request is already being accepted.
//  rst is synchronous and active high; it clears the controller, the output
//  valid and restores line_stride to 64.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer
  import bres_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // configuration
  input  logic                cfg_we,
  input  logic [STRIDE_W-1:0] cfg_wdata,
  // request side
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [COORD_W-1:0]  start_x,
  input  logic [COORD_W-1:0]  start_y,
  input  logic [COORD_W-1:0]  end_x,
  input  logic [COORD_W-1:0]  end_y,
  // pixel side
  output logic                out_valid,
  input  logic                out_stall,
  output logic [COORD_W-1:0]  pixel_x,
  output logic [COORD_W-1:0]  pixel_y,
  output logic [ADDR_W-1:0]   pixel_address,
  output logic                last_pixel
);

  // command and status between controller and datapath
  bres_cmd_t    cmd;
  bres_status_t status;

  // controller: idle until a request, then step once per free output slot
  bres_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: set-up, error term, address and output register
  bres_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .start_x       (start_x),
    .start_y       (start_y),
    .end_x         (end_x),
    .end_y         (end_y),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .pixel_address (pixel_address),
    .last_pixel    (last_pixel)
  );

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the line rasterizer. Line segment requests come
// first from a directed table of corners, axis, diagonal and near-tie
// segments, then as random segments across several stride settings. A
// behavioral Bresenham walk predicts every pixel not typed in the table.
// Each pixel leaving the block is compared field by field with the oldest
// prediction. Random gaps on the request side and random stalls on the
// pixel side, with one long hold-off, exercise the back-pressure path.
// ----------------------------------------------------------------------------
module testbench
  import bres_pkg::*;
();

  // Longest quiet stretch of a correct run is the receiver hold-off plus a
  // long stall and a long request gap. Allow several times that.
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int HOLD_OFF_AT     = 70;
  localparam int DRAIN_CYCLES    = 80;
  localparam int PHASE_ITEMS     = 35;
  localparam int PHASE_COUNT     = 6;
  localparam int REPORT_LIMIT    = 10;
  localparam int DIRECTED_ROWS   = 24;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x0, y0, x1, y1;
  } segment_t;

  typedef struct packed {
    coord_t              x;
    coord_t              y;
    logic [ADDR_W-1:0]   addr;
    logic                is_last;
  } pixel_t;

  typedef struct {
    segment_t seg;
    bit       typed;   // expectation typed in below, predictor not used
    pixel_t   want;
  } request_row_t;

  localparam pixel_t NO_PIXEL = '0;

  // Directed requests, all sent at the reset stride of 64.
  request_row_t directed_rows [DIRECTED_ROWS] = '{
    // single points at the corners and on alternating bit patterns
    '{'{6'd0,  6'd0,  6'd0,  6'd0 }, 1'b1, '{6'd0,  6'd0,  12'd0,    1'b1}},
    '{'{6'd63, 6'd63, 6'd63, 6'd63}, 1'b1, '{6'd63, 6'd63, 12'd4095, 1'b1}},
    '{'{6'd63, 6'd0,  6'd63, 6'd0 }, 1'b1, '{6'd63, 6'd0,  12'd63,   1'b1}},
    '{'{6'd0,  6'd63, 6'd0,  6'd63}, 1'b1, '{6'd0,  6'd63, 12'd4032, 1'b1}},
    '{'{6'd21, 6'd42, 6'd21, 6'd42}, 1'b1, '{6'd21, 6'd42, 12'd2709, 1'b1}},
    '{'{6'd42, 6'd21, 6'd42, 6'd21}, 1'b1, '{6'd42, 6'd21, 12'd1386, 1'b1}},
    // full-length axis lines, both directions
    '{'{6'd0,  6'd0,  6'd63, 6'd0 }, 1'b0, NO_PIXEL},
    '{'{6'd63, 6'd63, 6'd0,  6'd63}, 1'b0, NO_PIXEL},
    '{'{6'd0,  6'd0,  6'd0,  6'd63}, 1'b0, NO_PIXEL},
    '{'{6'd63, 6'd63, 6'd63, 6'd0 }, 1'b0, NO_PIXEL},
    // diagonals, full-length and short: deltas tie, so x is major
    '{'{6'd0,  6'd0,  6'd63, 6'd63}, 1'b0, NO_PIXEL},
    '{'{6'd0,  6'd63, 6'd63, 6'd0 }, 1'b0, NO_PIXEL},
    '{'{6'd63, 6'd63, 6'd0,  6'd0 }, 1'b0, NO_PIXEL},
    '{'{6'd2,  6'd5,  6'd5,  6'd2 }, 1'b0, NO_PIXEL},
    // shallow and steep slopes, minor rising and falling, swapped ends
    '{'{6'd0,  6'd10, 6'd63, 6'd20}, 1'b0, NO_PIXEL},
    '{'{6'd5,  6'd40, 6'd60, 6'd3 }, 1'b0, NO_PIXEL},
    '{'{6'd10, 6'd0,  6'd20, 6'd63}, 1'b0, NO_PIXEL},
    '{'{6'd50, 6'd60, 6'd12, 6'd1 }, 1'b0, NO_PIXEL},
    '{'{6'd30, 6'd0,  6'd31, 6'd63}, 1'b0, NO_PIXEL},
    // two-pixel segments
    '{'{6'd7,  6'd7,  6'd8,  6'd7 }, 1'b0, NO_PIXEL},
    '{'{6'd7,  6'd7,  6'd7,  6'd6 }, 1'b0, NO_PIXEL},
    '{'{6'd7,  6'd7,  6'd8,  6'd8 }, 1'b0, NO_PIXEL},
    // one more major step than minor steps
    '{'{6'd0,  6'd0,  6'd11, 6'd10}, 1'b0, NO_PIXEL},
    '{'{6'd11, 6'd10, 6'd0,  6'd0 }, 1'b0, NO_PIXEL}
  };

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cfg_we    = 1'b0;
  logic [STRIDE_W-1:0] cfg_wdata = '0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  coord_t              start_x   = '0;
  coord_t              start_y   = '0;
  coord_t              end_x     = '0;
  coord_t              end_y     = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  coord_t              pixel_x;
  coord_t              pixel_y;
  logic [ADDR_W-1:0]   pixel_address;
  logic                last_pixel;

  // Predictor state: the stride as last written, and the pixels still due.
  logic [STRIDE_W-1:0] stride_model = STRIDE_RESET;
  pixel_t              pending_pixels [$];
  int                  requests_sent  = 0;
  int                  error_count    = 0;
  int                  mismatch_count = 0;

  bresenham_line_rasterizer dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .start_x       (start_x),
    .start_y       (start_y),
    .end_x         (end_x),
    .end_y         (end_y),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .pixel_address (pixel_address),
    .last_pixel    (last_pixel)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Saturate a coordinate to the grid.
  function automatic int grid_limit(input coord_t c);
    return (int'(c) > GRID_SIZE - 1) ? GRID_SIZE - 1 : int'(c);
  endfunction

  // Walk one segment the Bresenham way and queue every pixel it covers,
  // ordered by rising major coordinate.
  function automatic void rasterize_segment(input segment_t seg);
    int     x0, y0, x1, y1, adx, ady;
    int     ma0, mi0, ma1, mi1, tmp;
    int     dmaj, dmin, dir, minor, acc, px, py;
    bit     x_major;
    pixel_t pix;
    x0 = grid_limit(seg.x0);
    y0 = grid_limit(seg.y0);
    x1 = grid_limit(seg.x1);
    y1 = grid_limit(seg.y1);
    adx = (x1 > x0) ? x1 - x0 : x0 - x1;
    ady = (y1 > y0) ? y1 - y0 : y0 - y1;
    // ties go to x
    x_major = (adx >= ady);
    if (x_major) begin
      ma0 = x0; mi0 = y0; ma1 = x1; mi1 = y1;
    end else begin
      ma0 = y0; mi0 = x0; ma1 = y1; mi1 = x1;
    end
    // swap the ends so the major coordinate rises
    if (ma1 < ma0) begin
      tmp = ma0; ma0 = ma1; ma1 = tmp;
      tmp = mi0; mi0 = mi1; mi1 = tmp;
    end
    dmaj = ma1 - ma0;
    dir  = (mi1 > mi0) ? 1 : -1;
    dmin = (mi1 > mi0) ? mi1 - mi0 : mi0 - mi1;
    acc   = dmaj;
    minor = mi0;
    for (int m = ma0; m <= ma1; m++) begin
      px = x_major ? m : minor;
      py = x_major ? minor : m;
      pix.x       = coord_t'(px);
      pix.y       = coord_t'(py);
      // address keeps its low bits only, wrapping on large strides
      pix.addr    = ADDR_W'(py * int'(stride_model) + px);
      pix.is_last = (m == ma1);
      pending_pixels.push_back(pix);
      // step the minor axis once the error passes twice the major delta
      acc += 2 * dmin;
      if (acc > 2 * dmaj) begin
        minor += dir;
        acc   -= 2 * dmaj;
      end
    end
  endfunction

  // Offer one request and hold it until accepted, then book its pixels.
  // Keep valid high straight into the next request when the gap is zero.
  task automatic offer_segment(input segment_t seg, input bit typed,
                               input pixel_t want, input int gap);
    in_valid <= 1'b1;
    start_x  <= seg.x0;
    start_y  <= seg.y0;
    end_x    <= seg.x1;
    end_y    <= seg.y1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (typed) pending_pixels.push_back(want);
    else rasterize_segment(seg);
    requests_sent++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Write the stride only once every booked pixel has left the block.
  // Callers leave valid low before calling.
  task automatic write_stride(input logic [STRIDE_W-1:0] value);
    while (pending_pixels.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we       <= 1'b0;
    stride_model = value;
  endtask

  // Request side: directed table, then random segments, one stride per phase.
  initial begin : stimulus
    logic [STRIDE_W-1:0] phase_strides [PHASE_COUNT];
    segment_t            seg;
    int                  kind, gap, pick, ax, ay, bx, by, d, tmp;
    bit                  no_idle;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed part at the reset stride
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      gap = (i == DIRECTED_ROWS - 1) ? 1 : $urandom_range(0, 2);
      offer_segment(directed_rows[i].seg, directed_rows[i].typed,
                    directed_rows[i].want, gap);
    end

    // smallest nonzero, zero, maximum (address wraps), nominal, random, just past range
    phase_strides[0] = 7'd1;
    phase_strides[1] = 7'd0;
    phase_strides[2] = 7'd127;
    phase_strides[3] = 7'd64;
    phase_strides[4] = STRIDE_W'($urandom_range(2, 126));
    phase_strides[5] = 7'd65;

    for (int p = 0; p < PHASE_COUNT; p++) begin
      write_stride(phase_strides[p]);
      // run one phase back to back with no request gaps
      no_idle = (p == 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        kind = $urandom_range(0, 99);
        ax = $urandom_range(0, GRID_SIZE - 1);
        ay = $urandom_range(0, GRID_SIZE - 1);
        bx = $urandom_range(0, GRID_SIZE - 1);
        by = $urandom_range(0, GRID_SIZE - 1);
        if (kind < 45) begin
          // anywhere on the grid
        end else if (kind < 70) begin
          // short segment near the start point
          bx = ax + int'($urandom_range(0, 8)) - 4;
          by = ay + int'($urandom_range(0, 8)) - 4;
          bx = (bx < 0) ? 0 : (bx > GRID_SIZE - 1) ? GRID_SIZE - 1 : bx;
          by = (by < 0) ? 0 : (by > GRID_SIZE - 1) ? GRID_SIZE - 1 : by;
        end else if (kind < 80) begin
          by = ay;
        end else if (kind < 88) begin
          bx = ax;
        end else if (kind < 95) begin
          // exact diagonal in either direction
          d  = (bx > ax) ? bx - ax : ax - bx;
          ay = $urandom_range(0, GRID_SIZE - 1 - d);
          by = ay + d;
          if ($urandom_range(0, 1) == 1) begin
            tmp = ay; ay = by; by = tmp;
          end
        end else begin
          bx = ax;
          by = ay;
        end
        seg = '{coord_t'(ax), coord_t'(ay), coord_t'(bx), coord_t'(by)};

        pick = $urandom_range(0, 99);
        if (i == PHASE_ITEMS - 1) gap = 1;
        else if (no_idle || pick < 70) gap = 0;
        else if (pick < 95) gap = $urandom_range(1, 3);
        else gap = $urandom_range(8, 30);
        offer_segment(seg, 1'b0, NO_PIXEL, gap);
      end
    end

    // drain, then give stray pixels time to show up
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_pixels.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Pixel side: check every accepted pixel against the oldest prediction,
  // then pick the stall for the next cycle.
  initial begin : pixel_sink
    int     stall_left, free_left, pick;
    bit     held;
    pixel_t got, want;
    stall_left = 0;
    free_left  = 0;
    held       = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        got = {pixel_x, pixel_y, pixel_address, last_pixel};
        if (pending_pixels.size() == 0) begin
          error_count++;
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("unexpected pixel: x=%0d y=%0d addr=%0d last=%0d",
                     got.x, got.y, got.addr, got.is_last);
        end else begin
          want = pending_pixels.pop_front();
          if (got !== want) begin
            error_count++;
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
              $display("pixel mismatch: expected x=%0d y=%0d addr=%0d last=%0d",
                       want.x, want.y, want.addr, want.is_last);
              $display("                got      x=%0d y=%0d addr=%0d last=%0d",
                       got.x, got.y, got.addr, got.is_last);
            end
          end
        end
      end

      // Hold off once for a long stretch while requests keep coming, so the
      // output register fills, the walk freezes and the request side stalls.
      if (!held && requests_sent >= HOLD_OFF_AT) begin
        held       = 1'b1;
        stall_left = HOLD_OFF_CYCLES;
        free_left  = 0;
      end
      if (stall_left == 0 && free_left == 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) free_left = $urandom_range(1, 24);
        else if (pick < 95) stall_left = $urandom_range(1, 3);
        else stall_left = $urandom_range(10, 40);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        free_left--;
      end
    end
  end

  // Watchdog: end the run when nothing has moved on any port for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("testbench: done, errors");
    $finish;
  end

endmodule
